[rtl/ple_pkg.sv]
package ple_pkg;

    localparam int CAPACITY    = 64;
    localparam int DATA_W      = 32;
    localparam int FUNC_W      = 3;
    localparam int STATUS_W    = 3;
    localparam int ENTRIES_W   = 7;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [FUNC_W-1:0] FUNC_APPEND     = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE_VAL = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE_AT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_INSERT     = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DUMP       = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NONE       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUMP_ENTRY = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DUMP_EMPTY = 3'd4;

    typedef enum logic [2:0] {
        OP_APPEND,
        OP_REMOVE_VAL,
        OP_REMOVE_AT,
        OP_INSERT,
        OP_DUMP
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
        logic        [DATA_W-1:0] position;
    } cmd_t;

endpackage

[rtl/ple_cmd_if.sv]
interface ple_cmd_if;
    logic                                valid;
    logic                                ready;
    logic        [ple_pkg::FUNC_W-1:0]   func;
    logic signed [ple_pkg::DATA_W-1:0]   value;
    logic signed [ple_pkg::DATA_W-1:0]   position;

    modport source (output valid, output func, output value, output position, input ready);
    modport sink   (input valid, input func, input value, input position, output ready);
endinterface

[rtl/ple_rsp_if.sv]
interface ple_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic        [ple_pkg::STATUS_W-1:0]  status;
    logic signed [ple_pkg::DATA_W-1:0]    item;
    logic        [ple_pkg::ENTRIES_W-1:0] entries;
    logic                                 last;

    modport source (output valid, output status, output item, output entries, output last,
                    input ready);
    modport sink   (input valid, input status, input item, input entries, input last,
                    output ready);
endinterface

[rtl/ple_ram.sv]
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/ple_front.sv]
module ple_front (
    ple_cmd_if.sink        cmd,
    output logic           push_valid,
    output ple_pkg::cmd_t  push_data,
    input  logic           push_ready
);
    logic known;

    always_comb
    begin
        known        = 1'b1;
        push_data.op = ple_pkg::OP_APPEND;
        case (cmd.func)
            ple_pkg::FUNC_APPEND:     push_data.op = ple_pkg::OP_APPEND;
            ple_pkg::FUNC_REMOVE_VAL: push_data.op = ple_pkg::OP_REMOVE_VAL;
            ple_pkg::FUNC_REMOVE_AT:  push_data.op = ple_pkg::OP_REMOVE_AT;
            ple_pkg::FUNC_INSERT:     push_data.op = ple_pkg::OP_INSERT;
            ple_pkg::FUNC_DUMP:       push_data.op = ple_pkg::OP_DUMP;
            default:                  known        = 1'b0;
        endcase
        push_data.value    = cmd.value;
        push_data.position = cmd.position;
    end

    // drop unknown codes on acceptance
    assign cmd.ready  = push_ready;
    assign push_valid = cmd.valid && known;
endmodule

[rtl/ple_queue.sv]
module ple_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  ple_pkg::cmd_t  push_data,
    output logic           push_ready,
    output logic           pop_valid,
    output ple_pkg::cmd_t  pop_data,
    input  logic           pop_ready
);
    localparam int PTR_W = (ple_pkg::QUEUE_DEPTH > 1) ? $clog2(ple_pkg::QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(ple_pkg::QUEUE_DEPTH + 1);

    ple_pkg::cmd_t     slot_reg [ple_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (fill_reg != FILL_W'(ple_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                slot_reg[wr_ptr_reg] <= push_data;
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(ple_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(ple_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - FILL_W'(1);
            end
        end
    end
endmodule

[rtl/ple_back.sv]
module ple_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    input  ple_pkg::cmd_t  pop_data,
    output logic           pop_ready,
    ple_rsp_if.source      rsp
);
    localparam int IDX_W    = ple_pkg::IDX_W;
    localparam int CNT_W    = ple_pkg::CNT_W;
    localparam int DATA_W   = ple_pkg::DATA_W;
    localparam int STATUS_W = ple_pkg::STATUS_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DEL_RD,
        S_DEL_WR,
        S_INS_RD,
        S_INS_WR,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_REPLY
    } state_t;

    state_t                state_reg,  state_next;
    logic [CNT_W-1:0]      count_reg,  count_next;
    logic [CNT_W-1:0]      ptr_reg,    ptr_next;
    logic [CNT_W-1:0]      slot_reg,   slot_next;
    logic [DATA_W-1:0]     value_reg,  value_next;
    logic [STATUS_W-1:0]   result_reg, result_next;
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [DATA_W-1:0]     out_item_reg, out_item_next;
    logic [CNT_W-1:0]      out_count_reg, out_count_next;
    logic                  out_last_reg, out_last_next;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [DATA_W-1:0]     ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [DATA_W-1:0]     ram_rdata;

    logic                  out_free;
    logic                  full;
    logic                  pos_end;
    logic [CNT_W-1:0]      ptr_inc;
    logic [CNT_W-1:0]      ptr_dec;

    ple_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ple_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free  = !out_valid_reg || rsp.ready;
    assign full      = (count_reg >= CNT_W'(ple_pkg::CAPACITY));
    assign pos_end   = pop_data.position[DATA_W-1] ||
                       (pop_data.position >= DATA_W'(count_reg));
    assign ptr_inc   = ptr_reg + CNT_W'(1);
    assign ptr_dec   = ptr_reg - CNT_W'(1);
    assign pop_ready = (state_reg == S_IDLE);

    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = out_status_reg;
    assign rsp.item    = out_item_reg;
    assign rsp.entries = ple_pkg::ENTRIES_W'(out_count_reg);
    assign rsp.last    = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        slot_next       = slot_reg;
        value_next      = value_reg;
        result_next     = result_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_item_next   = out_item_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[IDX_W-1:0];
        ram_wdata       = pop_data.value;
        ram_raddr       = ptr_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    value_next = pop_data.value;
                    case (pop_data.op)
                        ple_pkg::OP_APPEND:
                        begin
                            state_next = S_REPLY;
                            if (full)
                            begin
                                result_next = ple_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we      = 1'b1;
                                count_next  = count_reg + CNT_W'(1);
                                result_next = ple_pkg::ST_DONE;
                            end
                        end
                        ple_pkg::OP_REMOVE_VAL:
                        begin
                            ptr_next = '0;
                            if (count_reg == '0)
                            begin
                                result_next = ple_pkg::ST_NONE;
                                state_next  = S_REPLY;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        ple_pkg::OP_REMOVE_AT:
                        begin
                            if (pos_end)
                            begin
                                result_next = ple_pkg::ST_NONE;
                                state_next  = S_REPLY;
                            end
                            else
                            begin
                                ptr_next   = pop_data.position[CNT_W-1:0];
                                state_next = S_DEL_RD;
                            end
                        end
                        ple_pkg::OP_INSERT:
                        begin
                            if (full)
                            begin
                                result_next = ple_pkg::ST_FULL;
                                state_next  = S_REPLY;
                            end
                            else
                            begin
                                ptr_next   = count_reg;
                                slot_next  = pos_end ? count_reg
                                                     : pop_data.position[CNT_W-1:0];
                                state_next = S_INS_RD;
                            end
                        end
                        ple_pkg::OP_DUMP:
                        begin
                            ptr_next = '0;
                            if (count_reg == '0)
                            begin
                                result_next = ple_pkg::ST_DUMP_EMPTY;
                                state_next  = S_REPLY;
                            end
                            else
                            begin
                                state_next = S_DUMP_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (ram_rdata == value_reg)
                begin
                    state_next = S_DEL_RD;
                end
                else if (ptr_inc == count_reg)
                begin
                    result_next = ple_pkg::ST_NONE;
                    state_next  = S_REPLY;
                end
                else
                begin
                    ptr_next   = ptr_inc;
                    state_next = S_SCAN_RD;
                end
            end
            S_DEL_RD:
            begin
                // close the gap one entry at a time
                if (ptr_inc < count_reg)
                begin
                    ram_raddr  = ptr_inc[IDX_W-1:0];
                    state_next = S_DEL_WR;
                end
                else
                begin
                    count_next  = count_reg - CNT_W'(1);
                    result_next = ple_pkg::ST_DONE;
                    state_next  = S_REPLY;
                end
            end
            S_DEL_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ptr_reg[IDX_W-1:0];
                ram_wdata  = ram_rdata;
                ptr_next   = ptr_inc;
                state_next = S_DEL_RD;
            end
            S_INS_RD:
            begin
                // open a gap from the tail down to the insert slot
                if (ptr_reg > slot_reg)
                begin
                    ram_raddr  = ptr_dec[IDX_W-1:0];
                    state_next = S_INS_WR;
                end
                else
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = slot_reg[IDX_W-1:0];
                    ram_wdata   = value_reg;
                    count_next  = count_reg + CNT_W'(1);
                    result_next = ple_pkg::ST_DONE;
                    state_next  = S_REPLY;
                end
            end
            S_INS_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ptr_reg[IDX_W-1:0];
                ram_wdata  = ram_rdata;
                ptr_next   = ptr_dec;
                state_next = S_INS_RD;
            end
            S_DUMP_RD:
            begin
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT:
            begin
                // hold the read address so the data stays until the slot frees
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ple_pkg::ST_DUMP_ENTRY;
                    out_item_next   = ram_rdata;
                    out_count_next  = count_reg;
                    out_last_next   = (ptr_inc == count_reg);
                    if (ptr_inc == count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_inc;
                        state_next = S_DUMP_RD;
                    end
                end
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = result_reg;
                    out_item_next   = '0;
                    out_count_next  = count_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            ptr_reg        <= '0;
            slot_reg       <= '0;
            value_reg      <= '0;
            result_reg     <= ple_pkg::ST_DONE;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ple_pkg::ST_DONE;
            out_item_reg   <= '0;
            out_count_reg  <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ptr_reg        <= ptr_next;
            slot_reg       <= slot_next;
            value_reg      <= value_next;
            result_reg     <= result_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_item_reg   <= out_item_next;
            out_count_reg  <= out_count_next;
            out_last_reg   <= out_last_next;
        end
    end
endmodule

[rtl/positional_list_editor.sv]
// Ordered list of up to ple_pkg::CAPACITY signed 32-bit values in a single-port-write,
// registered-read RAM. Commands enter through a two-deep queue and run one at a time;
// unknown codes are accepted and dropped. Remove at position moves each later entry one
// place toward the head; insert moves each entry from the tail down to the insert slot
// one place toward the tail; remove by value scans from the head until the first match
// and then moves entries like remove at position, or answers none when nothing matches;
// dump reads out every entry, or answers empty for an empty list. A command dropped for
// a full list or a removal past the end is answered without touching the RAM. Each moved
// or scanned entry is a read state followed by a compare or write state in the RAM.
// A result waits in an output register while the next command is taken into the queue.
module positional_list_editor (
    input  logic       clk,
    input  logic       rst_n,
    ple_cmd_if.sink    cmd,
    ple_rsp_if.source  rsp
);
    logic          push_valid;
    logic          push_ready;
    ple_pkg::cmd_t push_data;
    logic          pop_valid;
    logic          pop_ready;
    ple_pkg::cmd_t pop_data;

    ple_front u_front (
        .cmd        (cmd),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    ple_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    ple_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .rsp       (rsp)
    );
endmodule

[bench/positional_list_editor_tb.sv]
module positional_list_editor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CLK_PERIOD     = 20;
    localparam int     RANDOM_ITEMS   = 260;
    localparam int     DRAIN_CYCLES   = 4 * ple_pkg::CAPACITY + 20;
    localparam longint TIMEOUT_CYCLES = 3_000_000;
    localparam int     MAX_PRINTED    = 30;

    localparam logic [ple_pkg::FUNC_W-1:0] FUNC_FIRST_UNUSED = ple_pkg::FUNC_DUMP + 1'b1;
    localparam logic [ple_pkg::FUNC_W-1:0] FUNC_LAST_UNUSED  = '1;

    typedef logic signed [ple_pkg::DATA_W-1:0] word_t;

    typedef struct packed {
        logic [ple_pkg::STATUS_W-1:0]  status;
        word_t                         item;
        logic [ple_pkg::ENTRIES_W-1:0] entries;
        logic                          last;
    } rsp_t;

    typedef enum {GROW, SHRINK, MIXED} phase_t;

    class list_scoreboard;
        word_t values_q[$];
        rsp_t  pending_rsp_q[$];
        int    errors;

        function int size();
            return values_q.size();
        endfunction

        function int pending();
            return pending_rsp_q.size();
        endfunction

        function word_t pick_entry();
            return values_q[$urandom_range(0, values_q.size() - 1)];
        endfunction

        function void add_rsp(logic [ple_pkg::STATUS_W-1:0] status, word_t item, logic last);
            rsp_t r;
            r.status  = status;
            r.item    = item;
            r.entries = ple_pkg::ENTRIES_W'(values_q.size());
            r.last    = last;
            pending_rsp_q.insert(pending_rsp_q.size(), r);
        endfunction

        function int end_or_index(word_t position);
            if (position[ple_pkg::DATA_W-1] || $unsigned(position) >= values_q.size())
                return values_q.size();
            return int'(position);
        endfunction

        function void note_command(logic [ple_pkg::FUNC_W-1:0] func, word_t value,
                                   word_t position);
            int idx;
            idx = -1;
            case (func)
                ple_pkg::FUNC_APPEND:
                begin
                    if (values_q.size() >= ple_pkg::CAPACITY)
                        add_rsp(ple_pkg::ST_FULL, '0, 1'b1);
                    else
                    begin
                        values_q.insert(values_q.size(), value);
                        add_rsp(ple_pkg::ST_DONE, '0, 1'b1);
                    end
                end
                ple_pkg::FUNC_REMOVE_VAL:
                begin
                    foreach (values_q[i])
                        if (idx < 0 && values_q[i] == value)
                            idx = i;
                    if (idx < 0)
                        add_rsp(ple_pkg::ST_NONE, '0, 1'b1);
                    else
                    begin
                        values_q.delete(idx);
                        add_rsp(ple_pkg::ST_DONE, '0, 1'b1);
                    end
                end
                ple_pkg::FUNC_REMOVE_AT:
                begin
                    idx = end_or_index(position);
                    if (idx >= values_q.size())
                        add_rsp(ple_pkg::ST_NONE, '0, 1'b1);
                    else
                    begin
                        values_q.delete(idx);
                        add_rsp(ple_pkg::ST_DONE, '0, 1'b1);
                    end
                end
                ple_pkg::FUNC_INSERT:
                begin
                    if (values_q.size() >= ple_pkg::CAPACITY)
                        add_rsp(ple_pkg::ST_FULL, '0, 1'b1);
                    else
                    begin
                        values_q.insert(end_or_index(position), value);
                        add_rsp(ple_pkg::ST_DONE, '0, 1'b1);
                    end
                end
                ple_pkg::FUNC_DUMP:
                begin
                    if (values_q.size() == 0)
                        add_rsp(ple_pkg::ST_DUMP_EMPTY, '0, 1'b1);
                    foreach (values_q[i])
                        add_rsp(ple_pkg::ST_DUMP_ENTRY, values_q[i],
                                i == values_q.size() - 1);
                end
                default:
                begin
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            if (errors < MAX_PRINTED)
                $display("%0t: mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(rsp_t got);
            rsp_t want;
            if (pending_rsp_q.size() == 0)
            begin
                report_mismatch("response with no command outstanding");
                return;
            end
            want = pending_rsp_q.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.item !== want.item)
                report_mismatch($sformatf("item got %0d want %0d", got.item, want.item));
            if (got.entries !== want.entries)
                report_mismatch($sformatf("entries got %0d want %0d",
                                          got.entries, want.entries));
            if (got.last !== want.last)
                report_mismatch($sformatf("last got %0b want %0b", got.last, want.last));
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit   calm;

    ple_cmd_if cmd_if();
    ple_rsp_if rsp_if();

    list_scoreboard sb = new();

    positional_list_editor u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int pick_gap();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic word_t rand_value();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return word_t'(int'($urandom_range(0, 4)) - 2);
        if (r == 3)
        begin
            case ($urandom_range(0, 3))
                0:       return {1'b0, {(ple_pkg::DATA_W-1){1'b1}}};
                1:       return {1'b1, {(ple_pkg::DATA_W-1){1'b0}}};
                2:       return '0;
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic word_t rand_position(int n);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(0, n);
        if (r == 6)
            return n;
        if (r == 7)
            return {1'b1, (ple_pkg::DATA_W-1)'($urandom)};
        if (r == 8)
            return $urandom;
        return {1'b0, (ple_pkg::DATA_W-1)'($urandom)};
    endfunction

    // ready side: random stalls, released while calm
    initial
    begin
        int stall;
        stall = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0 && !calm)
            begin
                rsp_if.ready = 1'b0;
                stall--;
            end
            else
            begin
                rsp_if.ready = 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_t'{status:  rsp_if.status,
                                   item:    rsp_if.item,
                                   entries: rsp_if.entries,
                                   last:    rsp_if.last});
    end

    task automatic send_cmd(logic [ple_pkg::FUNC_W-1:0] func, word_t value, word_t position);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_if.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_if.valid    = 1'b1;
        cmd_if.func     = func;
        cmd_if.value    = value;
        cmd_if.position = position;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        sb.note_command(func, value, position);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        cmd_if.valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [ple_pkg::FUNC_W-1:0] func;
        word_t                      value;
        word_t                      position;
        phase_t                     phase;
        int                         done_items;
        int                         full_hits;
        int                         empty_hits;
        int                         mixed_left;
        int unsigned                r;

        rst_n           = 1'b0;
        calm            = 1'b0;
        cmd_if.valid    = 1'b0;
        cmd_if.func     = ple_pkg::FUNC_APPEND;
        cmd_if.value    = '0;
        cmd_if.position = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_cmd(ple_pkg::FUNC_DUMP, '0, '0);
        send_cmd(ple_pkg::FUNC_REMOVE_VAL, '0, '0);
        send_cmd(ple_pkg::FUNC_REMOVE_AT, '0, '0);
        send_cmd(ple_pkg::FUNC_INSERT, 32'sd7, '1);
        send_cmd(ple_pkg::FUNC_APPEND, {1'b0, {(ple_pkg::DATA_W-1){1'b1}}}, '0);
        send_cmd(ple_pkg::FUNC_APPEND, {1'b1, {(ple_pkg::DATA_W-1){1'b0}}}, '0);
        send_cmd(ple_pkg::FUNC_APPEND, '0, '0);
        send_cmd(ple_pkg::FUNC_APPEND, '1, '0);
        send_cmd(ple_pkg::FUNC_INSERT, 32'h5555_5555, '0);
        send_cmd(ple_pkg::FUNC_INSERT, 32'hAAAA_AAAA, 32'sd2);
        send_cmd(ple_pkg::FUNC_INSERT, 32'sd7, {1'b0, {(ple_pkg::DATA_W-1){1'b1}}});
        send_cmd(ple_pkg::FUNC_INSERT, 32'sd9, {1'b1, {(ple_pkg::DATA_W-1){1'b0}}});
        send_cmd(ple_pkg::FUNC_DUMP, '0, '0);
        send_cmd(ple_pkg::FUNC_REMOVE_VAL, 32'sd7, '0);
        send_cmd(ple_pkg::FUNC_REMOVE_VAL, 32'sd12345, '0);
        send_cmd(ple_pkg::FUNC_REMOVE_AT, '0, '0);
        send_cmd(ple_pkg::FUNC_REMOVE_AT, '0, word_t'(sb.size() - 1));
        send_cmd(ple_pkg::FUNC_REMOVE_AT, '0, word_t'(sb.size()));
        send_cmd(ple_pkg::FUNC_REMOVE_AT, '0, '1);
        for (int f = FUNC_FIRST_UNUSED; f <= FUNC_LAST_UNUSED; f++)
            send_cmd(ple_pkg::FUNC_W'(f), '1, '1);
        send_cmd(ple_pkg::FUNC_DUMP, '0, '0);

        phase      = GROW;
        done_items = 0;
        full_hits  = 0;
        empty_hits = 0;
        mixed_left = 0;
        while (done_items < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            case (phase)
                GROW:
                    func = (r < 60) ? ple_pkg::FUNC_APPEND :
                           (r < 88) ? ple_pkg::FUNC_INSERT :
                           (r < 94) ? ple_pkg::FUNC_REMOVE_VAL : ple_pkg::FUNC_REMOVE_AT;
                SHRINK:
                    func = (r < 6)  ? ple_pkg::FUNC_APPEND :
                           (r < 12) ? ple_pkg::FUNC_INSERT :
                           (r < 55) ? ple_pkg::FUNC_REMOVE_VAL : ple_pkg::FUNC_REMOVE_AT;
                default:
                    func = (r < 25) ? ple_pkg::FUNC_APPEND :
                           (r < 50) ? ple_pkg::FUNC_INSERT :
                           (r < 75) ? ple_pkg::FUNC_REMOVE_VAL : ple_pkg::FUNC_REMOVE_AT;
            endcase
            r = $urandom_range(0, 99);
            if (r < 3)
                func = ple_pkg::FUNC_W'($urandom_range(FUNC_FIRST_UNUSED, FUNC_LAST_UNUSED));
            else if (r < 8)
                func = ple_pkg::FUNC_DUMP;

            if (func == ple_pkg::FUNC_REMOVE_VAL && sb.size() > 0 &&
                $urandom_range(0, 3) != 0)
                value = sb.pick_entry();
            else
                value = rand_value();
            position = rand_position(sb.size());

            if (phase == GROW && sb.size() == ple_pkg::CAPACITY &&
                (func == ple_pkg::FUNC_APPEND || func == ple_pkg::FUNC_INSERT))
                full_hits++;
            if (phase == SHRINK && sb.size() == 0 &&
                (func == ple_pkg::FUNC_REMOVE_VAL || func == ple_pkg::FUNC_REMOVE_AT))
                empty_hits++;

            send_cmd(func, value, position);
            if (func <= ple_pkg::FUNC_DUMP)
                done_items++;

            case (phase)
                GROW:
                begin
                    if (full_hits >= 6)
                    begin
                        full_hits = 0;
                        phase     = SHRINK;
                        wait_drained();
                    end
                end
                SHRINK:
                begin
                    if (empty_hits >= 3)
                    begin
                        empty_hits = 0;
                        phase      = MIXED;
                        mixed_left = 30;
                        calm       = 1'b1;
                    end
                end
                default:
                begin
                    mixed_left--;
                    if (mixed_left == 0)
                    begin
                        calm  = 1'b0;
                        phase = GROW;
                    end
                end
            endcase
        end

        send_cmd(ple_pkg::FUNC_DUMP, '0, '0);
        @(negedge clk);
        cmd_if.valid = 1'b0;
        calm         = 1'b1;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d responses never arrived", sb.pending()));

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
